### sv/shortest_remaining_time_scheduler_assert.svh
// ----------------------------------------------------------------------------
// SRTF scheduler assertion macros
// Concurrent assertion forms for the scheduler datapath
// ----------------------------------------------------------------------------
`ifndef SHORTEST_REMAINING_TIME_SCHEDULER_ASSERT_SVH
`define SHORTEST_REMAINING_TIME_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define SRTF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srtf assertion failed");

// next-cycle implication
`define SRTF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srtf assertion failed");

`endif

### sv/srtf_pkg.sv
// ----------------------------------------------------------------------------
// SRTF scheduler package
// Controller states, command and status bundles, item codes and field widths
// ----------------------------------------------------------------------------
package srtf_pkg;

   localparam int OUT_IDX_W  = 4;
   localparam int OUT_TIME_W = 17;

   localparam logic KIND_ADD = 1'b0;
   localparam logic KIND_RUN = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_STEP,
      ST_COMMIT,
      ST_REP_ADDR,
      ST_REP_TURN,
      ST_REP_OUT
   } srtf_state_type;

   typedef struct packed {
      logic add_wr;
      logic run_start;
      logic scan_rd;
      logic step;
      logic commit;
      logic rep_rd;
      logic rep_turn;
      logic rep_load;
      logic table_clear;
   } srtf_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic idx_last;
      logic all_done;
      logic rep_last;
      logic out_free;
   } srtf_sts_type;

endpackage

### sv/srtf_ctrl.sv
// ----------------------------------------------------------------------------
// SRTF scheduler controller
// Sequences adds, scan/step/commit rounds of the simulation and the reports
// ----------------------------------------------------------------------------
module srtf_ctrl
   import srtf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_kind,
   output logic         req_ready,
   input  srtf_sts_type sts,
   output srtf_cmd_type cmd
);

   srtf_state_type state_ff;
   srtf_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind == KIND_RUN) begin
                  cmd.run_start = 1'b1;
                  if (!sts.count_zero) begin
                     state_in = ST_SCAN;
                  end
               end else begin
                  cmd.add_wr = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (sts.idx_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_STEP;
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = sts.all_done ? ST_REP_ADDR : ST_SCAN;
         end
         ST_REP_ADDR: begin
            cmd.rep_rd = 1'b1;
            state_in   = ST_REP_TURN;
         end
         ST_REP_TURN: begin
            cmd.rep_turn = 1'b1;
            state_in     = ST_REP_OUT;
         end
         ST_REP_OUT: begin
            if (sts.out_free) begin
               cmd.rep_load = 1'b1;
               if (sts.rep_last) begin
                  cmd.table_clear = 1'b1;
                  state_in        = ST_IDLE;
               end else begin
                  state_in = ST_REP_ADDR;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### sv/srtf_dp.sv
// ----------------------------------------------------------------------------
// SRTF scheduler datapath
// Process table, per-entry scan, run-length step, clock and report registers
// ----------------------------------------------------------------------------
`include "shortest_remaining_time_scheduler_assert.svh"

module srtf_dp
   import srtf_pkg::*;
#(
   parameter int MAX_PROCS = 16,
   parameter int TIME_BITS = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  srtf_cmd_type            cmd,
   output srtf_sts_type            sts,
   input  logic [TIME_BITS-1:0]    req_arrival_time,
   input  logic [TIME_BITS-1:0]    req_burst_time,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [OUT_IDX_W-1:0]    rsp_process_index,
   output logic [OUT_TIME_W-1:0]   rsp_wait_time,
   output logic [OUT_TIME_W-1:0]   rsp_completion_time,
   output logic [OUT_TIME_W-1:0]   rsp_turnaround_time,
   output logic                    rsp_last
);

   localparam int IDX_W = $clog2(MAX_PROCS);
   localparam int CNT_W = $clog2(MAX_PROCS + 1);
   localparam int CLK_W = TIME_BITS + IDX_W + 1;
   localparam int EXT_W = CLK_W - TIME_BITS;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PROCS);
   localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

   // process table
   logic [TIME_BITS-1:0] arr_mem   [MAX_PROCS];
   logic [TIME_BITS-1:0] burst_mem [MAX_PROCS];
   logic [TIME_BITS-1:0] rem_mem   [MAX_PROCS];
   logic [CLK_W-1:0]     comp_mem  [MAX_PROCS];
   logic [MAX_PROCS-1:0] done_ff;

   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     left_ff;
   logic [CNT_W-1:0]     idx_ff;
   logic [CLK_W-1:0]     clock_ff;

   // registered read port
   logic                 eval_ff;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic [TIME_BITS-1:0] rd_arr_ff;
   logic [TIME_BITS-1:0] rd_burst_ff;
   logic [TIME_BITS-1:0] rd_rem_ff;
   logic [CLK_W-1:0]     rd_comp_ff;
   logic                 rd_done_ff;

   // scan accumulators
   logic                 have_pick_ff;
   logic [IDX_W-1:0]     pick_ff;
   logic [TIME_BITS-1:0] best_rem_ff;
   logic                 have_next_ff;
   logic [TIME_BITS-1:0] next_arr_ff;

   // step results
   logic [TIME_BITS-1:0] d_ff;
   logic                 fin_ff;
   logic [CLK_W-1:0]     turn_ff;

   // output register
   logic                  rsp_valid_ff;
   logic [OUT_IDX_W-1:0]  rsp_idx_ff;
   logic [OUT_TIME_W-1:0] rsp_wait_ff;
   logic [OUT_TIME_W-1:0] rsp_comp_ff;
   logic [OUT_TIME_W-1:0] rsp_turn_ff;
   logic                  rsp_last_ff;

   logic                  full;
   logic                  add_we;
   logic [TIME_BITS-1:0]  burst_fix;
   logic                  rd_issue;
   logic                  ready_entry;
   logic [TIME_BITS-1:0]  gap;
   logic                  gap_lt;
   logic [CLK_W-1:0]      d_ext;
   logic [CLK_W-1:0]      wait_val;
   logic [CLK_W+OUT_TIME_W-1:0] wait_wide;
   logic [CLK_W+OUT_TIME_W-1:0] comp_wide;
   logic [CLK_W+OUT_TIME_W-1:0] turn_wide;
   logic [IDX_W+OUT_IDX_W-1:0]  idx_wide;

   assign full      = (count_ff == MAX_CNT);
   assign add_we    = cmd.add_wr && !full;
   assign burst_fix = (req_burst_time == '0) ? TIME_BITS'(1) : req_burst_time;
   assign rd_issue  = cmd.scan_rd || cmd.rep_rd;

   assign ready_entry = ({{EXT_W{1'b0}}, rd_arr_ff} <= clock_ff);
   assign gap         = next_arr_ff - clock_ff[TIME_BITS-1:0];
   assign gap_lt      = have_next_ff && (gap < best_rem_ff);
   assign d_ext       = {{EXT_W{1'b0}}, d_ff};

   assign wait_val  = turn_ff - {{EXT_W{1'b0}}, rd_burst_ff};
   assign wait_wide = {{OUT_TIME_W{1'b0}}, wait_val};
   assign comp_wide = {{OUT_TIME_W{1'b0}}, rd_comp_ff};
   assign turn_wide = {{OUT_TIME_W{1'b0}}, turn_ff};
   assign idx_wide  = {{OUT_IDX_W{1'b0}}, rd_idx_ff};

   assign sts.count_zero = (count_ff == '0);
   assign sts.idx_last   = ((idx_ff + ONE_CNT) == count_ff);
   assign sts.all_done   = fin_ff && (left_ff == ONE_CNT);
   assign sts.rep_last   = ((CNT_W'(rd_idx_ff) + ONE_CNT) == count_ff);
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   // table memories
   always_ff @(posedge clock) begin
      if (add_we) begin
         arr_mem[count_ff[IDX_W-1:0]]   <= req_arrival_time;
         burst_mem[count_ff[IDX_W-1:0]] <= burst_fix;
      end
      if (add_we) begin
         rem_mem[count_ff[IDX_W-1:0]] <= burst_fix;
      end else if (cmd.commit && have_pick_ff) begin
         rem_mem[pick_ff] <= best_rem_ff - d_ff;
      end
      if (cmd.commit && fin_ff) begin
         comp_mem[pick_ff] <= clock_ff + d_ext;
      end
      if (rd_issue) begin
         rd_idx_ff   <= idx_ff[IDX_W-1:0];
         rd_arr_ff   <= arr_mem[idx_ff[IDX_W-1:0]];
         rd_burst_ff <= burst_mem[idx_ff[IDX_W-1:0]];
         rd_rem_ff   <= rem_mem[idx_ff[IDX_W-1:0]];
         rd_comp_ff  <= comp_mem[idx_ff[IDX_W-1:0]];
         rd_done_ff  <= done_ff[idx_ff[IDX_W-1:0]];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff  <= '0;
         count_ff <= '0;
         left_ff  <= '0;
         idx_ff   <= '0;
         clock_ff <= '0;
         eval_ff  <= 1'b0;
      end else begin
         eval_ff <= cmd.scan_rd;
         if (add_we) begin
            done_ff[count_ff[IDX_W-1:0]] <= 1'b0;
            count_ff                     <= count_ff + ONE_CNT;
         end
         if (cmd.table_clear) begin
            count_ff <= '0;
         end
         if (cmd.run_start) begin
            clock_ff <= '0;
            left_ff  <= count_ff;
         end
         if (cmd.run_start || cmd.commit) begin
            idx_ff <= '0;
         end else if (rd_issue) begin
            idx_ff <= idx_ff + ONE_CNT;
         end
         if (cmd.commit) begin
            clock_ff <= clock_ff + d_ext;
            if (fin_ff) begin
               done_ff[pick_ff] <= 1'b1;
               left_ff          <= left_ff - ONE_CNT;
            end
         end
      end
   end

   // scan over the table, one entry per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         have_pick_ff <= 1'b0;
         have_next_ff <= 1'b0;
      end else if (cmd.run_start || cmd.commit) begin
         have_pick_ff <= 1'b0;
         have_next_ff <= 1'b0;
      end else if (eval_ff && !rd_done_ff) begin
         if (ready_entry) begin
            if (!have_pick_ff || (rd_rem_ff < best_rem_ff)) begin
               have_pick_ff <= 1'b1;
               pick_ff      <= rd_idx_ff;
               best_rem_ff  <= rd_rem_ff;
            end
         end else if (!have_next_ff || (rd_arr_ff < next_arr_ff)) begin
            have_next_ff <= 1'b1;
            next_arr_ff  <= rd_arr_ff;
         end
      end
   end

   // run length up to the next event, or idle jump to the next arrival
   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff <= 1'b0;
      end else if (cmd.step) begin
         fin_ff <= have_pick_ff && !gap_lt;
         d_ff   <= (!have_pick_ff || gap_lt) ? gap : best_rem_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rep_turn) begin
         turn_ff <= rd_comp_ff - {{EXT_W{1'b0}}, rd_arr_ff};
      end
   end

   // report output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rep_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rep_load) begin
         rsp_idx_ff  <= idx_wide[OUT_IDX_W-1:0];
         rsp_wait_ff <= wait_wide[OUT_TIME_W-1:0];
         rsp_comp_ff <= comp_wide[OUT_TIME_W-1:0];
         rsp_turn_ff <= turn_wide[OUT_TIME_W-1:0];
         rsp_last_ff <= sts.rep_last;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_process_index   = rsp_idx_ff;
   assign rsp_wait_time       = rsp_wait_ff;
   assign rsp_completion_time = rsp_comp_ff;
   assign rsp_turnaround_time = rsp_turn_ff;
   assign rsp_last            = rsp_last_ff;

   `SRTF_ASSERT_IMPL(a_idle_has_next, clock, reset, cmd.step && !have_pick_ff, have_next_ff)
   `SRTF_ASSERT_IMPL(a_fin_has_left, clock, reset, cmd.commit && fin_ff, left_ff != '0)
   `SRTF_ASSERT_NEXT(a_clock_moves, clock, reset, cmd.commit, clock_ff > $past(clock_ff))
   `SRTF_ASSERT_IMPL(a_no_overwrite, clock, reset, cmd.rep_load, !rsp_valid_ff || rsp_ready)

endmodule

### sv/shortest_remaining_time_scheduler.sv
// ----------------------------------------------------------------------------
// Shortest remaining time scheduler
// Preemptive SRTF schedule of a loaded process table with per-process reports
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: kind 0 loads a process (arrival, burst) into the next table
//   slot; loads beyond MAX_PROCS are dropped. kind 1 runs the schedule over
//   the loaded table.
//   rsp_ channel: after a run, one transfer per loaded process in load order,
//   last set on the final one; the table is then empty again.
//   A run is event driven: the clock advances straight to the next arrival or
//   completion. Each event reads every loaded entry in turn, then passes a
//   drain state, a step and a commit; at most two events per process. Each
//   report reads its entry, forms its turnaround and waits out receiver stalls.
//   req_ready is high only while no run is in progress. The result register
//   holds a transfer until rsp_ready, and the next report waits behind it;
//   a new load can be taken while the final report still waits.
//   Reset empties the table and clears the result register; no clearing pass.
// ----------------------------------------------------------------------------
module shortest_remaining_time_scheduler
   import srtf_pkg::*;
#(
   parameter int MAX_PROCS = 16,
   parameter int TIME_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic [TIME_BITS-1:0]  req_arrival_time,
   input  logic [TIME_BITS-1:0]  req_burst_time,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [OUT_IDX_W-1:0]  rsp_process_index,
   output logic [OUT_TIME_W-1:0] rsp_wait_time,
   output logic [OUT_TIME_W-1:0] rsp_completion_time,
   output logic [OUT_TIME_W-1:0] rsp_turnaround_time,
   output logic                  rsp_last
);

   srtf_cmd_type cmd;
   srtf_sts_type sts;

   srtf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   srtf_dp #(
      .MAX_PROCS (MAX_PROCS),
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_arrival_time    (req_arrival_time),
      .req_burst_time      (req_burst_time),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_process_index   (rsp_process_index),
      .rsp_wait_time       (rsp_wait_time),
      .rsp_completion_time (rsp_completion_time),
      .rsp_turnaround_time (rsp_turnaround_time),
      .rsp_last            (rsp_last)
   );

endmodule
